/* design/htb_pkg.sv */
// Shared types, constants and character codes for the hex text to byte decoder.
package htb_pkg;

    // Width of the saturating byte counter; the digit counter is one bit wider.
    localparam int COUNT_BITS = 16;
    localparam int DIGIT_W    = COUNT_BITS + 1;
    localparam int LEN_W      = 16;
    // Width in which the decoded length and the length limits are compared.
    localparam int CMP_W      = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CH_LOW_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOW_F  = 8'h66;  // 'f'
    localparam logic [7:0] CH_LOW_X  = 8'h78;  // 'x'
    localparam logic [7:0] CH_UP_X   = 8'h58;  // 'X'
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DASH   = 8'h2D;  // '-'
    localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
    localparam logic [7:0] CASE_BIT  = 8'h20;
    localparam logic [3:0] HEX_TEN   = 4'd10;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_ODD_DIGIT = 3'd2,
        ST_NOT_EXACT = 3'd3,
        ST_TOO_SHORT = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    typedef enum logic {
        CFG_MIN_BYTES = 1'b0,
        CFG_MAX_BYTES = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
        logic       is_skip;
        logic       is_zero;
        logic       is_x;
    } t_char_class;

    typedef struct packed {
        logic             byte_valid;
        logic [7:0]       data_byte;
        logic             final_res;
        t_status          status;
        logic [LEN_W-1:0] total_bytes;
    } t_result;

endpackage

/* design/hex_text_to_bytes.sv */
// Top level of the hex text to byte decoder: input register, config registers, core.
//
// Streaming hexadecimal text decoder. At most one character word enters per cycle on
// the input channel and exactly one result word leaves for each, in order. Each word
// passes the input register, then the classify and pack logic into the result
// register; both stages hold under back-pressure, so the block sustains one word
// per cycle while the output side keeps up, and accepts a new word while a finished
// result still waits. Hex digits of either case pair
// into bytes, high nibble first, and a byte is shown (o_byte_valid) on the result
// of the character that completes it. Whitespace, '-', '{' and '}' are skipped; a
// "0x"/"0X" prefix is dropped by holding each '0' for one character. Any other
// character latches an invalid error and stops byte output until end of text, so
// the consumer must discard the streamed bytes when the final status is not OK.
// The result for the character marked i_end_of_text carries o_final_res, the
// status (invalid, odd/zero digit count, exact/min/max length, checked in that
// order) and the byte count, then all decode state returns to its reset value.
// The length limits are written through i_cfg_* (index 0 min, 1 max, 0 = off) and
// may only be changed while no words are in flight.
module hex_text_to_bytes (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [htb_pkg::LEN_W-1:0]  i_cfg_data,
    // character input
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_char_code,
    input  logic                       i_end_of_text,
    // result output
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_byte_valid,
    output logic [7:0]                 o_data_byte,
    output logic                       o_final_res,
    output logic [2:0]                 o_status,
    output logic [htb_pkg::LEN_W-1:0]  o_total_bytes
);

    logic [htb_pkg::LEN_W-1:0] r_min_bytes;
    logic [htb_pkg::LEN_W-1:0] r_max_bytes;

    // input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_char;
    logic       r_eot;

    logic                 w_take;     // core consumes the registered word
    logic                 w_out_valid;
    htb_pkg::t_char_class w_class;
    htb_pkg::t_result     w_result;

    // the core can take a word when its result slot is empty or draining now
    assign w_take     = r_in_valid && (!w_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_take;

    always_comb begin
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
        end else if (w_take) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char <= i_char_code;
            r_eot  <= i_end_of_text;
        end
    end

    // length limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bytes <= '0;
            r_max_bytes <= '0;
        end else if (i_cfg_we) begin
            unique case (htb_pkg::t_cfg_idx'(i_cfg_idx))
                htb_pkg::CFG_MIN_BYTES: r_min_bytes <= i_cfg_data;
                htb_pkg::CFG_MAX_BYTES: r_max_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    htb_classify u_classify (
        .i_char  (r_char),
        .o_class (w_class)
    );

    htb_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_class     (w_class),
        .i_eot       (r_eot),
        .i_min_bytes (r_min_bytes),
        .i_max_bytes (r_max_bytes),
        .i_out_ready (i_out_ready),
        .o_out_valid (w_out_valid),
        .o_result    (w_result)
    );

    assign o_out_valid   = w_out_valid;
    assign o_byte_valid  = w_result.byte_valid;
    assign o_data_byte   = w_result.data_byte;
    assign o_final_res   = w_result.final_res;
    assign o_status      = w_result.status;
    assign o_total_bytes = w_result.total_bytes;

endmodule

/* design/htb_classify.sv */
// Character classifier: hex digit value, separator and prefix detection.
module htb_classify (
    input  logic [7:0]           i_char,
    output htb_pkg::t_char_class o_class
);

    logic [7:0] w_lower;
    logic       w_dec;
    logic       w_alpha;

    assign w_lower = i_char | htb_pkg::CASE_BIT;
    assign w_dec   = (i_char >= htb_pkg::CH_ZERO) && (i_char <= htb_pkg::CH_NINE);
    assign w_alpha = (w_lower >= htb_pkg::CH_LOW_A) && (w_lower <= htb_pkg::CH_LOW_F);

    always_comb begin
        o_class.is_hex  = w_dec || w_alpha;
        if (w_dec) begin
            o_class.value = 4'(i_char - htb_pkg::CH_ZERO);
        end else if (w_alpha) begin
            o_class.value = 4'(w_lower - htb_pkg::CH_LOW_A) + htb_pkg::HEX_TEN;
        end else begin
            o_class.value = 4'h0;
        end
        o_class.is_skip = (i_char == htb_pkg::CH_SPACE)  || (i_char == htb_pkg::CH_TAB) ||
                          (i_char == htb_pkg::CH_CR)     || (i_char == htb_pkg::CH_LF)  ||
                          (i_char == htb_pkg::CH_DASH)   || (i_char == htb_pkg::CH_LBRACE) ||
                          (i_char == htb_pkg::CH_RBRACE);
        o_class.is_zero = (i_char == htb_pkg::CH_ZERO);
        o_class.is_x    = (i_char == htb_pkg::CH_LOW_X) || (i_char == htb_pkg::CH_UP_X);
    end

endmodule

/* design/htb_core.sv */
// Decode state, nibble packing, end-of-text status and the result register.
module htb_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  htb_pkg::t_char_class    i_class,
    input  logic                    i_eot,
    input  logic [htb_pkg::LEN_W-1:0] i_min_bytes,
    input  logic [htb_pkg::LEN_W-1:0] i_max_bytes,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output htb_pkg::t_result        o_result
);

    localparam logic [htb_pkg::DIGIT_W-1:0] DIGIT_MAX = '1;
    localparam logic [htb_pkg::CMP_W-1:0]   LEN_MAX   = htb_pkg::CMP_W'({htb_pkg::LEN_W{1'b1}});

    function automatic logic [htb_pkg::DIGIT_W-1:0] sat_inc(
        input logic [htb_pkg::DIGIT_W-1:0] cnt
    );
        return (cnt == DIGIT_MAX) ? cnt : cnt + 1'b1;
    endfunction

    logic                          r_lnn, n_lnn;      // next digit is a low nibble
    logic [3:0]                    r_hn, n_hn;        // pending high nibble
    logic                          r_held, n_held;    // a '0' is on hold
    logic [htb_pkg::DIGIT_W-1:0]   r_cnt, n_cnt;      // digit count, saturating
    logic                          r_inv, n_inv;      // sticky invalid flag
    logic                          r_out_valid, n_out_valid;
    htb_pkg::t_result              r_result, n_result;

    logic                          w_held_digit;
    logic                          w_drop_x;
    logic [htb_pkg::CMP_W-1:0]     w_total;
    logic [htb_pkg::CMP_W-1:0]     w_min;
    logic [htb_pkg::CMP_W-1:0]     w_max;

    assign w_held_digit = r_held && !i_class.is_x && !r_inv;
    assign w_drop_x     = r_held && i_class.is_x;
    assign w_min        = htb_pkg::CMP_W'(i_min_bytes);
    assign w_max        = htb_pkg::CMP_W'(i_max_bytes);

    always_comb begin
        n_lnn  = r_lnn;
        n_hn   = r_hn;
        n_held = 1'b0;
        n_cnt  = r_cnt;
        n_inv  = r_inv;
        n_result = '0;
        n_result.status = htb_pkg::ST_OK;

        // a held '0' not followed by x/X counts as a digit first
        if (w_held_digit) begin
            n_cnt = sat_inc(n_cnt);
            if (n_lnn) begin
                n_result.byte_valid = 1'b1;
                n_result.data_byte  = {n_hn, 4'h0};
                n_lnn = 1'b0;
            end else begin
                n_hn  = 4'h0;
                n_lnn = 1'b1;
            end
        end

        if (!w_drop_x) begin
            if (i_class.is_zero && !i_eot) begin
                n_held = 1'b1;
            end else if (i_class.is_hex) begin
                if (!r_inv) begin
                    n_cnt = sat_inc(n_cnt);
                    if (n_lnn) begin
                        n_result.byte_valid = 1'b1;
                        n_result.data_byte  = {n_hn, i_class.value};
                        n_lnn = 1'b0;
                    end else begin
                        n_hn  = i_class.value;
                        n_lnn = 1'b1;
                    end
                end
            end else if (!i_class.is_skip) begin
                n_inv = 1'b1;
            end
        end

        w_total = htb_pkg::CMP_W'(n_cnt[htb_pkg::DIGIT_W-1:1]);

        if (i_eot) begin
            n_result.final_res = 1'b1;
            priority if (n_inv) begin
                n_result.status = htb_pkg::ST_INVALID;
            end else if (n_cnt[0] || (n_cnt == '0)) begin
                n_result.status = htb_pkg::ST_ODD_DIGIT;
            end else if ((w_min != '0) && (w_min == w_max) && (w_total != w_min)) begin
                n_result.status = htb_pkg::ST_NOT_EXACT;
            end else if ((w_min != '0) && (w_total < w_min)) begin
                n_result.status = htb_pkg::ST_TOO_SHORT;
            end else if ((w_max != '0) && (w_total > w_max)) begin
                n_result.status = htb_pkg::ST_TOO_LONG;
            end else begin
                n_result.status = htb_pkg::ST_OK;
            end
            n_result.total_bytes = (w_total > LEN_MAX) ? {htb_pkg::LEN_W{1'b1}}
                                                       : w_total[htb_pkg::LEN_W-1:0];
            n_lnn  = 1'b0;
            n_hn   = 4'h0;
            n_held = 1'b0;
            n_cnt  = '0;
            n_inv  = 1'b0;
        end
    end

    always_comb begin
        if (i_take) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lnn       <= 1'b0;
            r_hn        <= 4'h0;
            r_held      <= 1'b0;
            r_cnt       <= '0;
            r_inv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_take) begin
                r_lnn  <= n_lnn;
                r_hn   <= n_hn;
                r_held <= n_held;
                r_cnt  <= n_cnt;
                r_inv  <= n_inv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

/* bench/testbench.sv */
// Self-checking bench for hex_text_to_bytes: directed and random hex texts against a decoder model.
package htb_check_pkg;
    import htb_pkg::*;

    localparam logic [7:0] K_ZERO   = "0";
    localparam logic [7:0] K_NINE   = "9";
    localparam logic [7:0] K_LOW_A  = "a";
    localparam logic [7:0] K_LOW_F  = "f";
    localparam logic [7:0] K_UP_A   = "A";
    localparam logic [7:0] K_LOW_X  = "x";
    localparam logic [7:0] K_UP_X   = "X";
    localparam logic [7:0] K_SPACE  = " ";
    localparam logic [7:0] K_TAB    = "\t";
    localparam logic [7:0] K_CR     = "\r";
    localparam logic [7:0] K_LF     = "\n";
    localparam logic [7:0] K_DASH   = "-";
    localparam logic [7:0] K_LBRACE = "{";
    localparam logic [7:0] K_RBRACE = "}";
    localparam logic [7:0] K_CASE   = 8'h20;
    localparam logic [7:0] K_TEN    = 8'd10;
    localparam int         DIGITS_W = 17;

    // Decoder model plus the queue of result words still owed by the block.
    class hex_decode_sb;
        t_result              want_q[$];
        bit                   low_next;
        logic [3:0]           hi_nib;
        bit                   zero_held;
        logic [DIGITS_W-1:0]  digits;
        bit                   bad_seen;
        logic [15:0]          min_len;
        logic [15:0]          max_len;
        int                   n_errors;
        int                   n_words;

        function new();
            min_len  = '0;
            max_len  = '0;
            n_errors = 0;
            n_words  = 0;
            clear_text();
        endfunction

        function void clear_text();
            low_next  = 1'b0;
            hi_nib    = '0;
            zero_held = 1'b0;
            digits    = '0;
            bad_seen  = 1'b0;
        endfunction

        function void set_limit(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_MIN_BYTES: min_len = val;
                CFG_MAX_BYTES: max_len = val;
            endcase
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        // 0..15 for a hex digit of either case, -1 for anything else
        static function int hex_val(logic [7:0] c);
            logic [7:0] lc;
            if (c >= K_ZERO && c <= K_NINE)
                return int'(c - K_ZERO);
            lc = c | K_CASE;
            if (lc >= K_LOW_A && lc <= K_LOW_F)
                return int'(lc - K_LOW_A) + int'(K_TEN);
            return -1;
        endfunction

        static function bit is_skip(logic [7:0] c);
            return c == K_SPACE || c == K_TAB || c == K_CR || c == K_LF ||
                   c == K_DASH || c == K_LBRACE || c == K_RBRACE;
        endfunction

        // packs one nibble; returns 1 with the byte when it completes one
        function bit push_digit(logic [3:0] v, output logic [7:0] b);
            b = '0;
            if (bad_seen)
                return 1'b0;
            if (digits != '1)
                digits++;
            if (low_next) begin
                low_next = 1'b0;
                b = {hi_nib, v};
                return 1'b1;
            end
            hi_nib   = v;
            low_next = 1'b1;
            return 1'b0;
        endfunction

        // called for every accepted character word
        function void note_char(logic [7:0] c, logic last);
            t_result     r;
            logic [7:0]  b;
            logic [15:0] total;
            int          v;
            bit          prefix;
            r      = '0;
            prefix = 1'b0;
            if (zero_held) begin
                zero_held = 1'b0;
                if (c == K_LOW_X || c == K_UP_X)
                    prefix = 1'b1;
                else if (push_digit(4'h0, b)) begin
                    r.byte_valid = 1'b1;
                    r.data_byte  = b;
                end
            end
            if (!prefix) begin
                if (c == K_ZERO && !last) begin
                    zero_held = 1'b1;
                end else begin
                    v = hex_val(c);
                    if (v >= 0) begin
                        if (push_digit(4'(v), b)) begin
                            r.byte_valid = 1'b1;
                            r.data_byte  = b;
                        end
                    end else if (!is_skip(c)) begin
                        bad_seen = 1'b1;
                    end
                end
            end
            if (last) begin
                total         = digits[DIGITS_W-1:1];
                r.final_res   = 1'b1;
                r.total_bytes = total;
                if (bad_seen)
                    r.status = ST_INVALID;
                else if (digits[0] || digits == '0)
                    r.status = ST_ODD_DIGIT;
                else if (min_len != '0 && min_len == max_len && total != min_len)
                    r.status = ST_NOT_EXACT;
                else if (min_len != '0 && total < min_len)
                    r.status = ST_TOO_SHORT;
                else if (max_len != '0 && total > max_len)
                    r.status = ST_TOO_LONG;
                else
                    r.status = ST_OK;
                clear_text();
            end
            want_q.insert(want_q.size(), r);
        endfunction

        task report(string msg);
            n_errors++;
            if (n_errors <= 40)
                $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task cmp(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("word %0d %s got %0h want %0h", n_words, field, got, want));
        endtask

        // called for every accepted result word
        task check_word(logic bv, logic [7:0] db, logic fr, logic [2:0] st, logic [15:0] tb);
            t_result want;
            n_words++;
            if (want_q.size() == 0) begin
                report($sformatf("word %0d arrived with nothing expected", n_words));
                return;
            end
            want = want_q.pop_front();
            cmp("byte_valid", 16'(bv), 16'(want.byte_valid));
            cmp("data_byte", 16'(db), 16'(want.data_byte));
            cmp("final_res", 16'(fr), 16'(want.final_res));
            cmp("status", 16'(st), 16'(want.status));
            cmp("total_bytes", tb, want.total_bytes);
        endtask
    endclass
endpackage

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import htb_pkg::*;
    import htb_check_pkg::*;

    localparam int IDLE_LIMIT  = 2000;  // cycles without any handshake before giving up
    localparam int PHASE_CHARS = 155;   // random characters per limit setting
    localparam int NUM_PHASES  = 12;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    t_cfg_idx         i_cfg_idx     = CFG_MIN_BYTES;
    logic [LEN_W-1:0] i_cfg_data    = '0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_ready;
    logic [7:0]       i_char_code   = '0;
    logic             i_end_of_text = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready   = 1'b0;
    logic             o_byte_valid;
    logic [7:0]       o_data_byte;
    logic             o_final_res;
    logic [2:0]       o_status;
    logic [LEN_W-1:0] o_total_bytes;

    hex_decode_sb sb;
    logic [7:0]   text_q[$];
    int           burst_left  = 1;
    int           chars_sent  = 0;
    int           idle_cycles = 0;
    int           sink_left   = 0;
    int           sink_phase  = 0;
    logic [1:0]   sink_mode   = 2'd0;

    hex_text_to_bytes uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor: both channels sampled at the edge, values as the block saw them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_char(i_char_code, i_end_of_text);
            if (o_out_valid && i_out_ready)
                sb.check_word(o_byte_valid, o_data_byte, o_final_res, o_status, o_total_bytes);
        end
    end

    // Watchdog: any word moving on either side resets the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Result sink: hops between always ready, light and heavy random stalls,
    // and a fixed 5-of-8 duty pattern.
    always @(posedge i_clk) begin
        sink_phase <= sink_phase + 1;
        if (sink_left == 0) begin
            sink_mode <= 2'($urandom_range(0, 3));
            sink_left <= $urandom_range(8, 120);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= ($urandom_range(0, 4) != 0);
            2'd2: i_out_ready <= ($urandom_range(0, 9) < 3);
            default: i_out_ready <= (sink_phase % 8 < 5);
        endcase
    end

    function automatic logic [7:0] rand_digit();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < K_TEN)
            return K_ZERO + v;
        if ($urandom_range(0, 1) != 0)
            return K_UP_A + v - K_TEN;
        return K_LOW_A + v - K_TEN;
    endfunction

    function automatic logic [7:0] rand_x();
        return ($urandom_range(0, 1) != 0) ? K_LOW_X : K_UP_X;
    endfunction

    function automatic logic [7:0] rand_sep();
        case ($urandom_range(0, 6))
            0: return K_SPACE;
            1: return K_TAB;
            2: return K_CR;
            3: return K_LF;
            4: return K_DASH;
            5: return K_LBRACE;
            default: return K_RBRACE;
        endcase
    endfunction

    // anything that is neither a hex digit nor a separator, high codes included
    function automatic logic [7:0] rand_bad();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (hex_decode_sb::hex_val(c) >= 0 || hex_decode_sb::is_skip(c));
        return c;
    endfunction

    // appends one character to the text being built
    function automatic void append_char(logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    // One character word. Valid stays up into the next call unless the burst
    // runs out, in which case it drops for a short random gap.
    task send_char(logic [7:0] c, logic last);
        i_in_valid    <= 1'b1;
        i_char_code   <= c;
        i_end_of_text <= last;
        do @(posedge i_clk); while (!o_in_ready);
        chars_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every owed result word is back, then settle.
    task quiesce();
        if (i_in_valid)
            i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task set_limits(logic [15:0] lo, logic [15:0] hi);
        quiesce();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIN_BYTES;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_BYTES;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_limit(CFG_MIN_BYTES, lo);
        sb.set_limit(CFG_MAX_BYTES, hi);
    endtask

    // Sends text_q with end of text on its last character; may stop mid-text
    // until the block has drained.
    task send_text(bit may_pause);
        for (int i = 0; i < text_q.size(); i++) begin
            if (may_pause && $urandom_range(0, 299) == 0)
                quiesce();
            send_char(text_q[i], i == text_q.size() - 1);
        end
    endtask

    // Mostly well-formed hex texts (optionally with 0x prefixes and separators),
    // some of them broken by one edit, and some plain noise.
    task make_text();
        int kind;
        int nb;
        bit per_byte_prefix;
        kind = $urandom_range(0, 99);
        text_q.delete();
        if (kind < 80) begin
            per_byte_prefix = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                append_char(rand_sep());
            if (!per_byte_prefix && $urandom_range(0, 2) == 0) begin
                append_char(K_ZERO);
                append_char(rand_x());
            end
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            for (int i = 0; i < nb; i++) begin
                if (per_byte_prefix) begin
                    append_char(K_ZERO);
                    append_char(rand_x());
                end
                append_char(rand_digit());
                append_char(rand_digit());
                if ($urandom_range(0, 2) == 0)
                    append_char(rand_sep());
            end
            if (kind >= 60 && text_q.size() > 0) begin
                case ($urandom_range(0, 3))
                    0: text_q.insert($urandom_range(0, text_q.size() - 1), rand_digit());
                    1: text_q.insert($urandom_range(0, text_q.size() - 1), rand_bad());
                    2: text_q.insert($urandom_range(0, text_q.size() - 1), K_ZERO);
                    default: begin
                        nb = $urandom_range(1, text_q.size());
                        text_q = text_q[0:nb-1];
                    end
                endcase
            end
        end else begin
            nb = $urandom_range(1, 10);
            for (int i = 0; i < nb; i++) begin
                case ($urandom_range(0, 4))
                    0, 1: append_char(8'($urandom_range(0, 255)));
                    2: append_char(rand_digit());
                    3: append_char(($urandom_range(0, 1) != 0) ? K_ZERO : rand_x());
                    default: append_char(rand_sep());
                endcase
            end
        end
        if (text_q.size() == 0)
            append_char(rand_sep());
    endtask

    initial begin
        int start;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed texts, limits still at their reset value (off)
        text_q = '{"0", "X", "a", "F"};              // upper-case prefix dropped -> AF
        send_text(0);
        send_char(K_ZERO, 1'b0);                     // held zero that is a digit -> 01
        send_char("1", 1'b0);
        quiesce();                                   // sender waits out the block mid-text
        send_char("9", 1'b0);
        send_char(K_ZERO, 1'b1);                     // zero on the last word is a digit
        text_q = '{"7", "0", 8'h00};                 // held zero still yields 70, then invalid
        send_text(0);
        text_q = '{"A", 8'hFF, "b", "c"};            // high code is invalid, no later bytes
        send_text(0);
        text_q = '{"{", "d", " ", "\t", "E", "\r", "\n", "-", "}"};  // all separators -> DE
        send_text(0);
        text_q = '{"-"};                             // no digits at all
        send_text(0);
        text_q = '{"x", "0"};                        // x without a zero ahead is invalid
        send_text(0);

        // random texts over a spread of length limits
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_limits(16'd0, 16'd0);
                1: set_limits(16'd1, 16'd1);
                2: set_limits(16'd3, 16'd0);
                3: set_limits(16'd0, 16'd4);
                4: set_limits(16'd2, 16'd6);
                5: set_limits(16'd5, 16'd5);
                6: set_limits(16'hFFFF, 16'd0);
                7: set_limits(16'd0, 16'hFFFF);
                8: set_limits(16'd1, 16'hFFFF);
                9: set_limits(16'd4, 16'd2);
                10: set_limits(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
                default: set_limits(16'($urandom_range(0, 65535)),
                                    16'($urandom_range(0, 65535)));
            endcase
            start = chars_sent;
            while (chars_sent - start < PHASE_CHARS) begin
                make_text();
                send_text(1);
            end
        end

        quiesce();
        repeat (8) @(posedge i_clk);
        if (sb.n_errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

/* sim.f */
design/htb_pkg.sv
design/htb_classify.sv
design/htb_core.sv
design/hex_text_to_bytes.sv
bench/testbench.sv
